// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold cond at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Require cons in the same cycle as ante.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Require cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/gocc_pkg.sv
// Package for the grid obstacle clearance classifier: field widths, codes
// and the compass ray step table. No dependencies.
`timescale 1ns / 1ps

package gocc_pkg;

  localparam int MAX_SIDE_DEF = 64;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int CODE_W  = 2;
  localparam int CLASS_W = 3;
  localparam int SIDE_W  = 7;
  localparam int SD_W    = 6;
  localparam int DIST_W  = SD_W + 1;
  localparam int DIR_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CODE_W-1:0] CODE_FREE     = 2'd0;
  localparam logic [CODE_W-1:0] CODE_OBSTACLE = 2'd1;

  localparam logic [CLASS_W-1:0] CLASS_FREE        = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_UNREACHABLE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_DIST = 2'd1;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 7'd64;
  localparam logic [DIR_W-1:0]  DIR_LAST      = 3'd7;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_ADD,
    STEP_SUB
  } step_t;

  // Row step of compass direction k, clockwise from north.
  function automatic step_t row_step(input logic [DIR_W-1:0] k);
    step_t s;
    case (k)
      3'd0, 3'd1, 3'd7: s = STEP_SUB;
      3'd3, 3'd4, 3'd5: s = STEP_ADD;
      default:          s = STEP_NONE;
    endcase
    return s;
  endfunction

  // Column step of compass direction k, clockwise from north.
  function automatic step_t col_step(input logic [DIR_W-1:0] k);
    step_t s;
    case (k)
      3'd1, 3'd2, 3'd3: s = STEP_ADD;
      3'd5, 3'd6, 3'd7: s = STEP_SUB;
      default:          s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/gocc_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module gocc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/grid_obstacle_clearance_classifier_unit.sv
// Occupancy grid clearance classifier. Write words (tuser 0) store one cell code. Query
// words (tuser 1) go straight to the result when out of range, and end after the centre
// cell read when the cell is not free, the clearance is zero or the clearance reaches
// the grid edge; otherwise the one grid RAM port is read once per cycle along the eight
// compass rays and the scan stops at the first obstacle. Depends on gocc_pkg, gocc_ram
// and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_obstacle_clearance_classifier_unit #(
  parameter int MAX_SIDE = gocc_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // cfg_data: grid_side[6:0] or safe_distance[5:0]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gocc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gocc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata: row[5:0], col[11:6], cell_code[13:12], zero[15:14]
  input  logic [gocc_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: op[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: cell_class[2:0], zero[7:3]
  output logic [gocc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: range_error[0]
  output logic                             out_tuser
);

  import gocc_pkg::*;

  localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW     = ($clog2(MAX_SIDE + 1) > SIDE_W) ? $clog2(MAX_SIDE + 1) : SIDE_W;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CENTER,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [SIDE_W-1:0]   grid_side_r;
  logic [SD_W-1:0]     safe_dist_r;
  logic [CW-1:0]       row0_r, row0_nxt;
  logic [CW-1:0]       col0_r, col0_nxt;
  logic                edge_r, edge_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [DIR_W-1:0]    dir_r, dir_nxt;
  logic                last_pend_r, last_pend_nxt;
  logic [CLASS_W-1:0]  res_class_r, res_class_nxt;
  logic                res_rerr_r, res_rerr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0]  out_class_r, out_class_nxt;
  logic                out_rerr_r, out_rerr_nxt;

  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    in_col;
  logic [CODE_W-1:0]   in_code;
  logic [CW-1:0]       in_row_c, in_col_c, side_eff, sd_c, dist_c;
  logic [CW-1:0]       ray_row, ray_col;
  logic                in_range_err, in_edge, in_fits_mem;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr, in_addr, ray_addr;
  logic [CODE_W-1:0]   ram_rdata;

  assign in_row  = in_tdata[ROW_W-1:0];
  assign in_col  = in_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_code = in_tdata[ROW_W+COL_W+CODE_W-1:ROW_W+COL_W];

  assign in_row_c = CW'(in_row);
  assign in_col_c = CW'(in_col);
  assign sd_c     = CW'(safe_dist_r);
  assign dist_c   = CW'(dist_r);
  assign side_eff = (CW'(grid_side_r) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(grid_side_r);

  assign in_range_err = (in_row_c >= side_eff) || (in_col_c >= side_eff);
  assign in_fits_mem  = (in_row_c < CW'(MAX_SIDE)) && (in_col_c < CW'(MAX_SIDE));
  assign in_edge      = (in_row_c < sd_c) || (in_col_c < sd_c) ||
                        (in_row_c + sd_c >= side_eff) || (in_col_c + sd_c >= side_eff);
  assign in_addr      = {in_row_c[IDX_W-1:0], in_col_c[IDX_W-1:0]};

  always_comb begin
    case (row_step(dir_r))
      STEP_ADD: ray_row = row0_r + dist_c;
      STEP_SUB: ray_row = row0_r - dist_c;
      default:  ray_row = row0_r;
    endcase
    case (col_step(dir_r))
      STEP_ADD: ray_col = col0_r + dist_c;
      STEP_SUB: ray_col = col0_r - dist_c;
      default:  ray_col = col0_r;
    endcase
  end

  assign ray_addr = {ray_row[IDX_W-1:0], ray_col[IDX_W-1:0]};

  gocc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_code),
    .rdata (ram_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_class_r);
  assign out_tuser  = out_rerr_r;

  always_comb begin
    state_nxt     = state_r;
    row0_nxt      = row0_r;
    col0_nxt      = col0_r;
    edge_nxt      = edge_r;
    dist_nxt      = dist_r;
    dir_nxt       = dir_r;
    last_pend_nxt = last_pend_r;
    res_class_nxt = res_class_r;
    res_rerr_nxt  = res_rerr_r;
    out_class_nxt = out_class_r;
    out_rerr_nxt  = out_rerr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_addr      = ray_addr;

    case (state_r)
      S_IDLE: begin
        ram_addr = in_addr;
        if (in_tvalid) begin
          if (in_tuser == OP_WRITE) begin
            ram_we = in_fits_mem;
          end else if (in_range_err) begin
            res_class_nxt = CLASS_FREE;
            res_rerr_nxt  = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            row0_nxt     = in_row_c;
            col0_nxt     = in_col_c;
            edge_nxt     = in_edge;
            dist_nxt     = DIST_W'(1);
            dir_nxt      = '0;
            res_rerr_nxt = 1'b0;
            state_nxt    = S_CENTER;
          end
        end
      end
      S_CENTER: begin
        if (ram_rdata != CODE_FREE || safe_dist_r == '0) begin
          res_class_nxt = CLASS_W'(ram_rdata);
          state_nxt     = S_EMIT;
        end else if (edge_r) begin
          res_class_nxt = CLASS_UNREACHABLE;
          state_nxt     = S_EMIT;
        end else begin
          last_pend_nxt = (dist_r == DIST_W'(safe_dist_r)) && (dir_r == DIR_LAST);
          dir_nxt       = dir_r + 1'b1;
          dist_nxt      = (dir_r == DIR_LAST) ? dist_r + 1'b1 : dist_r;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ram_rdata == CODE_OBSTACLE) begin
          res_class_nxt = CLASS_UNREACHABLE;
          state_nxt     = S_EMIT;
        end else if (last_pend_r) begin
          res_class_nxt = CLASS_FREE;
          state_nxt     = S_EMIT;
        end else begin
          last_pend_nxt = (dist_r == DIST_W'(safe_dist_r)) && (dir_r == DIR_LAST);
          dir_nxt       = dir_r + 1'b1;
          dist_nxt      = (dir_r == DIR_LAST) ? dist_r + 1'b1 : dist_r;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_class_nxt = res_class_r;
          out_rerr_nxt  = res_rerr_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      grid_side_r <= GRID_SIDE_RST;
      safe_dist_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_SIDE: grid_side_r <= cfg_data[SIDE_W-1:0];
          REG_SAFE_DIST: safe_dist_r <= cfg_data[SD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    row0_r      <= row0_nxt;
    col0_r      <= col0_nxt;
    edge_r      <= edge_nxt;
    dist_r      <= dist_nxt;
    dir_r       <= dir_nxt;
    last_pend_r <= last_pend_nxt;
    res_class_r <= res_class_nxt;
    res_rerr_r  <= res_rerr_nxt;
    out_class_r <= out_class_nxt;
    out_rerr_r  <= out_rerr_nxt;
  end

  `ASSERT_IMPLIES(a_scan_needs_clearance, state_r == S_SCAN, safe_dist_r != '0,
    "ray scan running with zero clearance")
  `ASSERT_IMPLIES(a_scan_dist_bound, state_r == S_SCAN && !last_pend_r,
    dist_r <= DIST_W'(safe_dist_r), "ray distance beyond clearance")
  `ASSERT_IMPLIES(a_range_err_class, out_valid_r && out_rerr_r, out_class_r == CLASS_FREE,
    "range error with nonzero class")
  `ASSERT_NEXT(a_write_no_result, in_tvalid && in_tready && in_tuser == OP_WRITE,
    state_r == S_IDLE, "write left idle state")

endmodule
